// File: rtl/psx_pkg.sv
package psx_pkg;

   // Default sizing
   localparam int LEN_BITS_DEFAULT    = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Key register reset values
   localparam logic [31:0] XOR_KEY_RESET    = 32'h2FDB3CED;
   localparam logic [31:0] ROTATE_KEY_RESET = 32'hAFD33C8D;

   // Register indexes on the csr port
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_XOR_KEY    = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROTATE_KEY = 1'b1;

   // Packet direction
   localparam logic FUNC_ENCODE = 1'b0;
   localparam logic FUNC_DECODE = 1'b1;

   // One unit of work handed from the front end to the back end
   typedef struct packed {
      logic        fault;      // single bad-frame result
      logic        has_nonce;  // four nonce bytes go out first
      logic [31:0] nonce;
      logic        has_word;   // one body word follows
      logic        dir;
      logic [31:0] word;       // raw gathered word
      logic [31:0] mix;
      logic [4:0]  rot;
      logic [3:0]  mask;       // word bytes that go out
      logic        last;       // byte 3 of the word closes the packet
   } psx_entry_type;

   function automatic logic [31:0] rotl32(input logic [31:0] w, input logic [4:0] r);
      logic [63:0] t;
      t = {w, w} << r;
      return t[63:32];
   endfunction

   function automatic logic [31:0] rotr32(input logic [31:0] w, input logic [4:0] r);
      logic [63:0] t;
      t = {w, w} >> r;
      return t[31:0];
   endfunction

   function automatic logic [31:0] enc_word(input logic [31:0] w, input logic [31:0] mix,
                                            input logic [4:0] rot);
      return rotl32(w ^ mix, rot);
   endfunction

   function automatic logic [31:0] dec_word(input logic [31:0] w, input logic [31:0] mix,
                                            input logic [4:0] rot);
      return rotr32(w, rot) ^ mix;
   endfunction

endpackage

// File: rtl/packet_scrambler_xor_rotate_unit.sv
// Channel   Handshake          Payload
// request   push / full        req_func, req_pkt_len, req_rand_value, req_data_byte,
//                              req_byte_valid, req_last
// response  empty / pop        rsp_out_byte, rsp_out_last, rsp_bad_frame
// csr       csr_we (no wait)   csr_index, csr_wdata (xor_key, rotate_key)
//
// One request byte per cycle while full is low; the back end sends one response byte per cycle while pop keeps up.
// A result passes through the entry queue, the current-entry registers and the output register to the response ports.
// The entry queue (QUEUE_DEPTH entries) absorbs bursts: up to eight bytes from a packet's
// first transfer; full rises when the queue is full and falls as the back end drains.
// Synchronous reset clears the queue, the packet counter and restores the key defaults.
module packet_scrambler_xor_rotate_unit
   import psx_pkg::*;
#(
   parameter int LEN_BITS    = LEN_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic                      req_func,
   input  logic [15:0]               req_pkt_len,
   input  logic [31:0]               req_rand_value,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_byte_valid,
   input  logic                      req_last,
   output logic                      empty,
   input  logic                      pop,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_out_last,
   output logic                      rsp_bad_frame,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0]               csr_wdata
);

   logic          accept;
   logic          enq_valid;
   psx_entry_type enq_entry;
   psx_entry_type head;
   logic          q_full;
   logic          q_empty;
   logic          q_pop;

   assign full   = q_full;
   assign accept = push && !q_full;

   psx_front #(
      .LEN_BITS (LEN_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .req_func       (req_func),
      .req_pkt_len    (req_pkt_len),
      .req_rand_value (req_rand_value),
      .req_data_byte  (req_data_byte),
      .req_byte_valid (req_byte_valid),
      .req_last       (req_last),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .enq_valid      (enq_valid),
      .enq_entry      (enq_entry)
   );

   psx_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (enq_valid),
      .wr_data (enq_entry),
      .rd_en   (q_pop),
      .rd_data (head),
      .full    (q_full),
      .empty   (q_empty)
   );

   psx_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .empty         (empty),
      .pop           (pop),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_last  (rsp_out_last),
      .rsp_bad_frame (rsp_bad_frame)
   );

endmodule

// File: rtl/psx_front.sv
module psx_front
   import psx_pkg::*;
#(
   parameter int LEN_BITS = LEN_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic                      req_func,
   input  logic [15:0]               req_pkt_len,
   input  logic [31:0]               req_rand_value,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_byte_valid,
   input  logic                      req_last,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0]               csr_wdata,
   output logic                      enq_valid,
   output psx_entry_type             enq_entry
);

   localparam int LW = LEN_BITS + 1;

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_NONCE   = 2'd1;
   localparam logic [1:0] PH_BODY    = 2'd2;
   localparam logic [1:0] PH_SWALLOW = 2'd3;

   logic [1:0]    phase_ff, phase_in;
   logic          dir_ff, dir_in;
   logic [7:0]    counter_ff, counter_in;
   logic [31:0]   mix_ff, mix_in;
   logic [4:0]    rot_ff, rot_in;
   logic [23:0]   gather_ff, gather_in;
   logic [1:0]    slot_ff, slot_in;
   logic [LW-1:0] pos_ff, pos_in;
   logic [LW-1:0] blen_ff, blen_in;
   logic [31:0]   xor_key_ff, xor_key_in;
   logic [31:0]   rotate_key_ff, rotate_key_in;

   logic [LEN_BITS-1:0] len;
   logic [LW-1:0]       len_ext, len_plus5, enc_blen, pad_diff;
   logic [1:0]          pad_k;
   logic [2:0]          hdr_len, k_plus1, seq_len;
   logic                take_byte;
   logic [7:0]          counter_next;
   logic [47:0]         hdr_seq;
   logic [31:0]         enc_mix, enc_rot_word;
   logic [31:0]         raw_word, nonce_mix, nonce_rot_word, dec_word_q;

   // Encode framing: k, k zero pads, counter, then payload
   assign len          = LEN_BITS'(req_pkt_len);
   assign len_ext      = LW'(len);
   assign len_plus5    = len_ext + LW'(5);
   assign enc_blen     = {len_plus5[LW-1:2], 2'b00};
   assign pad_diff     = enc_blen - len_ext - LW'(2);
   assign pad_k        = pad_diff[1:0];
   assign hdr_len      = {1'b0, pad_k} + 3'd2;
   assign k_plus1      = {1'b0, pad_k} + 3'd1;
   assign take_byte    = req_byte_valid && (LW'(hdr_len) < enc_blen);
   assign seq_len      = hdr_len + {2'b00, take_byte};
   assign counter_next = counter_ff + 8'd1;
   assign hdr_seq      = (take_byte ? ({40'd0, req_data_byte} << {hdr_len, 3'b000}) : 48'd0)
                       | ({40'd0, counter_next} << {k_plus1, 3'b000})
                       | {46'd0, pad_k};
   assign enc_mix      = 32'(enc_blen) ^ xor_key_ff ^ req_rand_value;
   assign enc_rot_word = 32'(enc_blen) ^ rotate_key_ff ^ req_rand_value;

   // Word completed by this byte
   assign raw_word       = {req_data_byte, gather_ff};
   assign nonce_mix      = 32'(blen_ff) ^ xor_key_ff ^ raw_word;
   assign nonce_rot_word = 32'(blen_ff) ^ rotate_key_ff ^ raw_word;
   assign dec_word_q     = dec_word(raw_word, mix_ff, rot_ff);

   // Key registers
   always_comb begin
      xor_key_in    = xor_key_ff;
      rotate_key_in = rotate_key_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_XOR_KEY:    xor_key_in    = csr_wdata;
            CSR_ROTATE_KEY: rotate_key_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Classify each transfer and build queue entries
   always_comb begin
      phase_in   = phase_ff;
      dir_in     = dir_ff;
      counter_in = counter_ff;
      mix_in     = mix_ff;
      rot_in     = rot_ff;
      gather_in  = gather_ff;
      slot_in    = slot_ff;
      pos_in     = pos_ff;
      blen_in    = blen_ff;

      enq_valid          = 1'b0;
      enq_entry          = '0;
      enq_entry.dir      = dir_ff;
      enq_entry.mix      = mix_ff;
      enq_entry.rot      = rot_ff;
      enq_entry.mask     = 4'hF;
      enq_entry.word     = raw_word;

      if (accept) begin
         unique case (phase_ff)
            PH_IDLE: begin
               dir_in    = req_func;
               gather_in = '0;
               slot_in   = '0;
               pos_in    = '0;
               if (req_func == FUNC_ENCODE) begin
                  // nonce bytes plus the header, maybe one full word
                  counter_in          = counter_next;
                  blen_in             = enc_blen;
                  mix_in              = enc_mix;
                  rot_in              = enc_rot_word[4:0];
                  enq_valid           = 1'b1;
                  enq_entry.dir       = FUNC_ENCODE;
                  enq_entry.mix       = enc_mix;
                  enq_entry.rot       = enc_rot_word[4:0];
                  enq_entry.has_nonce = 1'b1;
                  enq_entry.nonce     = req_rand_value;
                  enq_entry.has_word  = seq_len[2];
                  enq_entry.word      = hdr_seq[31:0];
                  enq_entry.last      = (enc_blen == LW'(4));
                  gather_in           = seq_len[2] ? {8'd0, hdr_seq[47:32]} : hdr_seq[23:0];
                  slot_in             = seq_len[1:0];
                  pos_in              = LW'(seq_len);
                  phase_in            = PH_BODY;
               end else if ((len < LEN_BITS'(8)) || (len[1:0] != 2'd0)) begin
                  enq_valid       = 1'b1;
                  enq_entry.fault = 1'b1;
                  phase_in        = PH_SWALLOW;
               end else begin
                  blen_in  = len_ext - LW'(4);
                  phase_in = PH_NONCE;
                  if (req_byte_valid) begin
                     gather_in = {16'd0, req_data_byte};
                     slot_in   = 2'd1;
                  end
               end
            end
            PH_NONCE: begin
               if (req_byte_valid) begin
                  if (slot_ff != 2'd3) begin
                     gather_in[{slot_ff, 3'b000} +: 8] = req_data_byte;
                     slot_in = slot_ff + 2'd1;
                  end else begin
                     mix_in    = nonce_mix;
                     rot_in    = nonce_rot_word[4:0];
                     gather_in = '0;
                     slot_in   = '0;
                     pos_in    = '0;
                     phase_in  = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               if (req_byte_valid) begin
                  if (slot_ff != 2'd3) begin
                     if ((dir_ff == FUNC_DECODE) || (pos_ff < blen_ff)) begin
                        gather_in[{slot_ff, 3'b000} +: 8] = req_data_byte;
                        slot_in = slot_ff + 2'd1;
                        if (dir_ff == FUNC_ENCODE) begin
                           pos_in = pos_ff + LW'(1);
                        end
                     end
                  end else if (dir_ff == FUNC_ENCODE) begin
                     if (pos_ff < blen_ff) begin
                        enq_valid      = 1'b1;
                        enq_entry.has_word = 1'b1;
                        enq_entry.last = (pos_ff + LW'(1) == blen_ff);
                        gather_in      = '0;
                        slot_in        = '0;
                        pos_in         = pos_ff + LW'(1);
                     end
                  end else if ((pos_ff == '0) && (dec_word_q[7:2] != 6'd0)) begin
                     // pad count out of range
                     enq_valid       = 1'b1;
                     enq_entry.fault = 1'b1;
                     phase_in        = PH_SWALLOW;
                  end else begin
                     enq_entry.has_word = 1'b1;
                     enq_entry.mask     = (pos_ff == '0) ? (4'b1110 << dec_word_q[1:0]) : 4'hF;
                     enq_entry.last     = (pos_ff + LW'(4) == blen_ff);
                     enq_valid          = (enq_entry.mask != 4'd0);
                     gather_in          = '0;
                     slot_in            = '0;
                     pos_in             = pos_ff + LW'(4);
                  end
               end
            end
            PH_SWALLOW: ;
            default: ;
         endcase

         // close the packet on a complete body or on last
         if ((phase_in == PH_BODY) && (pos_in >= blen_in)) begin
            phase_in = PH_IDLE;
         end
         if (req_last) begin
            phase_in = PH_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         dir_ff        <= FUNC_ENCODE;
         counter_ff    <= '0;
         slot_ff       <= '0;
         xor_key_ff    <= XOR_KEY_RESET;
         rotate_key_ff <= ROTATE_KEY_RESET;
      end else begin
         phase_ff      <= phase_in;
         dir_ff        <= dir_in;
         counter_ff    <= counter_in;
         slot_ff       <= slot_in;
         xor_key_ff    <= xor_key_in;
         rotate_key_ff <= rotate_key_in;
      end
   end

   always_ff @(posedge clock) begin
      mix_ff    <= mix_in;
      rot_ff    <= rot_in;
      gather_ff <= gather_in;
      pos_ff    <= pos_in;
      blen_ff   <= blen_in;
   end

endmodule

// File: rtl/psx_queue.sv
module psx_queue
   import psx_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  psx_entry_type wr_data,
   input  logic          rd_en,
   output psx_entry_type rd_data,
   output logic          full,
   output logic          empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   psx_entry_type         entry_ff [DEPTH];
   logic [PW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]         count_ff, count_in;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = entry_ff[rd_ptr_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + CW'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: rtl/psx_back.sv
module psx_back
   import psx_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  psx_entry_type head,
   input  logic          q_empty,
   output logic          q_pop,
   output logic          empty,
   input  logic          pop,
   output logic [7:0]    rsp_out_byte,
   output logic          rsp_out_last,
   output logic          rsp_bad_frame
);

   logic [7:0][7:0] cur_bytes_ff, cur_bytes_in;
   logic [8:0]      cur_slots_ff, cur_slots_in;
   logic            cur_last_ff, cur_last_in;
   logic            out_valid_ff, out_valid_in;
   logic [7:0]      out_byte_ff, out_byte_in;
   logic            out_last_ff, out_last_in;
   logic            out_bad_ff, out_bad_in;

   logic            out_free;
   logic            send;
   logic [8:0]      sel_onehot;
   logic [8:0]      remaining;
   logic [7:0]      sel_byte;
   logic [31:0]     head_word;

   assign out_free   = !out_valid_ff || pop;
   assign sel_onehot = cur_slots_ff & (~cur_slots_ff + 9'd1);
   assign send       = out_free && (cur_slots_ff != 9'd0);
   assign remaining  = send ? (cur_slots_ff & ~sel_onehot) : cur_slots_ff;
   assign q_pop      = (remaining == 9'd0) && !q_empty;
   assign head_word  = (head.dir == FUNC_ENCODE) ? enc_word(head.word, head.mix, head.rot)
                                                 : dec_word(head.word, head.mix, head.rot);

   // Pick the byte of the lowest pending slot
   always_comb begin
      sel_byte = 8'd0;
      for (int i = 0; i < 8; i++) begin
         if (sel_onehot[i]) begin
            sel_byte = sel_byte | cur_bytes_ff[i];
         end
      end
   end

   // Load the next entry as the current one drains
   always_comb begin
      cur_bytes_in = cur_bytes_ff;
      cur_slots_in = remaining;
      cur_last_in  = cur_last_ff;
      if (q_pop) begin
         cur_bytes_in = {head_word, head.nonce};
         cur_slots_in = {head.fault,
                         head.has_word ? head.mask : 4'd0,
                         head.has_nonce ? 4'hF : 4'd0};
         cur_last_in  = head.last;
      end
   end

   // Output register: hold while stalled
   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_bad_in   = out_bad_ff;
      if (out_free) begin
         out_valid_in = send;
         out_byte_in  = sel_byte;
         out_last_in  = sel_onehot[8] || (sel_onehot[7] && cur_last_ff);
         out_bad_in   = sel_onehot[8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_slots_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_slots_ff <= cur_slots_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_bytes_ff <= cur_bytes_in;
      cur_last_ff  <= cur_last_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      out_bad_ff   <= out_bad_in;
   end

   assign empty         = !out_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_out_last  = out_last_ff;
   assign rsp_bad_frame = out_bad_ff;

endmodule
